// ===== design/procedural_texel_generator_top_macros.svh =====
// ============================================================================
// Assertion macros for the procedural texel generator.
// Assertions are compiled in unless SYNTH is defined.
// ============================================================================
`ifndef PROCEDURAL_TEXEL_GENERATOR_TOP_MACROS_SVH
`define PROCEDURAL_TEXEL_GENERATOR_TOP_MACROS_SVH
`ifndef SYNTH
`define PTG_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define PTG_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PTG_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define PTG_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/ptg_pkg.sv =====
// ============================================================================
// Procedural texel generator package
// Types, constants and helper functions shared by the design.
// ============================================================================
package ptg_pkg;

    localparam int NumTexturesDef = 8;
    localparam int RulesPerTextureDef = 8;
    localparam int CoordBitsDef = 12;
    localparam int WordsPerRule = 16;
    localparam int WordSelValid = 16;

    localparam logic [3:0] W_PKIND = 4'd0;
    localparam logic [3:0] W_XM    = 4'd1;
    localparam logic [3:0] W_XD    = 4'd2;
    localparam logic [3:0] W_YM    = 4'd3;
    localparam logic [3:0] W_YD    = 4'd4;
    localparam logic [3:0] W_NM    = 4'd5;
    localparam logic [3:0] W_M     = 4'd6;
    localparam logic [3:0] W_E     = 4'd7;
    localparam logic [3:0] W_L     = 4'd8;
    localparam logic [3:0] W_RKIND = 4'd9;
    localparam logic [3:0] W_SOLID = 4'd10;
    localparam logic [3:0] W_CA    = 4'd11;
    localparam logic [3:0] W_CB    = 4'd12;
    localparam logic [3:0] W_BASE  = 4'd13;
    localparam logic [3:0] W_K     = 4'd14;
    localparam logic [3:0] W_D     = 4'd15;

    localparam logic [31:0] PK_ALWAYS = 32'd0;
    localparam logic [31:0] PK_EQ     = 32'd1;
    localparam logic [31:0] PK_LT     = 32'd2;
    localparam logic [31:0] RK_MIX    = 32'd1;

    localparam logic [1:0] FAULT_OK   = 2'd0;
    localparam logic [1:0] FAULT_NONE = 2'd1;
    localparam logic [1:0] FAULT_DIV  = 2'd2;

    localparam logic [2:0] REG_XMULT = 3'd0;
    localparam logic [2:0] REG_YMULT = 3'd1;
    localparam logic [2:0] REG_SMULT = 3'd2;
    localparam logic [2:0] REG_SHIFT = 3'd3;
    localparam logic [2:0] REG_ALPHA = 3'd4;

    typedef struct packed {
        logic        req_type;
        logic [11:0] pix_x;
        logic [11:0] pix_y;
        logic [2:0]  texture_sel;
        logic [2:0]  rule_slot;
        logic [4:0]  word_sel;
        logic signed [31:0] word_value;
    } t_in_item;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [1:0] fault;
    } t_out_item;

    // Item handed from the front end to the back end.
    typedef struct packed {
        logic        req_type;
        logic [11:0] pix_x;
        logic [11:0] pix_y;
        logic [2:0]  texture_sel;
        logic [2:0]  rule_slot;
        logic [4:0]  word_sel;
        logic [31:0] word_value;
        logic [31:0] noise;
    } t_job;

endpackage

// ===== design/procedural_texel_generator_top.sv =====
// ============================================================================
// Procedural texel generator
// Hash noise front end, serial rule search back end, one texel per texel request.
// ============================================================================
//  channel | handshake           | payload
//  in      | push / full         | i_in (t_in_item)
//  out     | empty / pop         | o_out (t_out_item)
//  cfg     | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// A texel search steps over invalid rule slots, loads the 16 words of each
// valid rule and evaluates it on the shared one-bit-per-cycle divider; a mod
// predicate and a mix each add further divisions.
// Reset is synchronous and clears control state and rule valid bits.
// The output register holds one texel; the search stalls until it is popped.
module procedural_texel_generator_top
    import ptg_pkg::*;
#(
    parameter int NUM_TEXTURES = NumTexturesDef,
    parameter int RULES_PER_TEXTURE = RulesPerTextureDef,
    parameter int COORD_BITS = CoordBitsDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_in_item    i_in,
    input  logic        push,
    output logic        full,
    output t_out_item   o_out,
    output logic        empty,
    input  logic        pop,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    logic [31:0] r_xmult, r_ymult, r_smult;
    logic [4:0]  r_shift;
    logic [7:0]  r_alpha;
    t_job        w_job;
    logic        w_job_valid, w_job_take;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xmult <= '0;
            r_ymult <= '0;
            r_smult <= '0;
            r_shift <= '0;
            r_alpha <= 8'hff;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_XMULT: r_xmult <= i_cfg_data;
                REG_YMULT: r_ymult <= i_cfg_data;
                REG_SMULT: r_smult <= i_cfg_data;
                REG_SHIFT: r_shift <= i_cfg_data[4:0];
                REG_ALPHA: r_alpha <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    ptg_front #(.COORD_BITS(COORD_BITS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_item(i_in), .i_push(push),
        .o_full(full), .i_xmult(r_xmult), .i_ymult(r_ymult), .i_smult(r_smult),
        .i_shift(r_shift), .o_job(w_job), .o_job_valid(w_job_valid),
        .i_job_take(w_job_take)
    );

    ptg_back #(.NUM_TEXTURES(NUM_TEXTURES), .RULES_PER_TEXTURE(RULES_PER_TEXTURE)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_job(w_job), .i_job_valid(w_job_valid),
        .o_job_take(w_job_take), .i_alpha(r_alpha), .o_item(o_out),
        .o_empty(empty), .i_pop(pop)
    );
endmodule

// ===== design/ptg_ram.sv =====
// ============================================================================
// Generic single-port RAM
// One write or one read per cycle, registered read data.
// ============================================================================
module ptg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// ===== design/ptg_divider.sv =====
// ============================================================================
// Iterative signed divider
// Truncating 33-bit signed division, one quotient bit per cycle.
// ============================================================================
module ptg_divider
    import ptg_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [32:0] i_num,
    input  logic signed [32:0] i_den,
    output logic               o_done,
    output logic signed [32:0] o_quo,
    output logic signed [32:0] o_rem
);
    logic        r_busy, n_busy;
    logic [5:0]  r_cnt, n_cnt;
    logic [32:0] r_q, n_q;
    logic [33:0] r_r, n_r;
    logic [32:0] r_d, n_d;
    logic        r_nq, n_nq, r_nr, n_nr;
    logic        r_done, n_done;
    logic [33:0] w_sh;
    logic [33:0] w_sub;

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_r    = r_r;
        n_d    = r_d;
        n_nq   = r_nq;
        n_nr   = r_nr;
        n_done = 1'b0;
        w_sh   = {r_r[32:0], r_q[32]};
        w_sub  = w_sh - {1'b0, r_d};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = 6'd33;
            n_q    = i_num[32] ? 33'(-i_num) : i_num;
            n_d    = i_den[32] ? 33'(-i_den) : i_den;
            n_r    = '0;
            n_nq   = i_num[32] ^ i_den[32];
            n_nr   = i_num[32];
        end else if (r_busy) begin
            if (!w_sub[33]) begin
                n_r = w_sub;
                n_q = {r_q[31:0], 1'b1};
            end else begin
                n_r = w_sh;
                n_q = {r_q[31:0], 1'b0};
            end
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_q   <= n_q;
        r_r   <= n_r;
        r_d   <= n_d;
        r_nq  <= n_nq;
        r_nr  <= n_nr;
    end

    assign o_done = r_done;
    assign o_quo  = r_nq ? 33'(-r_q) : r_q;
    assign o_rem  = r_nr ? 33'(-r_r[32:0]) : r_r[32:0];
endmodule

// ===== design/ptg_front.sv =====
// ============================================================================
// Texel generator front end
// Accepts items, computes the hash noise and queues jobs for the back end.
// ============================================================================
module ptg_front
    import ptg_pkg::*;
#(
    parameter int COORD_BITS = CoordBitsDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_in_item    i_item,
    input  logic        i_push,
    output logic        o_full,
    input  logic [31:0] i_xmult,
    input  logic [31:0] i_ymult,
    input  logic [31:0] i_smult,
    input  logic [4:0]  i_shift,
    output t_job        o_job,
    output logic        o_job_valid,
    input  logic        i_job_take
);
    localparam logic [11:0] CoordMask = 12'((1 << COORD_BITS) - 1);

    // Stage 1: products.
    logic        r_s1_v;
    t_in_item    r_s1;
    logic [31:0] r_px, r_py, r_ps;
    // Stage 2: noise.
    logic        r_s2_v;
    t_in_item    r_s2;
    logic [31:0] r_nz;
    // Two-entry job queue.
    t_job        r_q [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;

    logic [31:0] w_v, w_sh, w_x;
    logic        w_adv, w_push_q, w_pop_q;
    logic [11:0] w_x_in, w_y_in;
    logic [1:0]  w_occ;
    t_in_item    w_item_m;

    // Pipeline occupancy plus queue must fit the two queue entries.
    assign w_occ  = r_cnt + 2'(r_s1_v) + 2'(r_s2_v);
    assign o_full = (r_cnt + 2'(r_s1_v) + 2'(r_s2_v)) >= 2'd2 || (r_cnt == 2'd2);
    assign w_adv  = 1'b1;

    assign w_x_in = i_item.pix_x & CoordMask;
    assign w_y_in = i_item.pix_y & CoordMask;

    always_comb begin
        w_item_m       = i_item;
        w_item_m.pix_x = w_x_in;
        w_item_m.pix_y = w_y_in;
    end

    always_comb begin
        w_v  = r_px ^ r_py ^ r_ps;
        w_sh = 32'($signed(w_v) >>> i_shift);
        w_x  = w_v ^ w_sh;
        if (w_x[31]) begin
            w_x = 32'(-w_x);
        end
    end

    assign w_push_q = r_s2_v;
    assign w_pop_q  = i_job_take && (r_cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_s1_v <= i_push && !o_full && w_adv;
            r_s2_v <= r_s1_v;
            if (w_push_q) begin
                r_wp <= !r_wp;
            end
            if (w_pop_q) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push_q) - 2'(w_pop_q);
        end
        r_s1 <= w_item_m;
        r_px <= 32'(w_x_in) * i_xmult;
        r_py <= 32'(w_y_in) * i_ymult;
        r_ps <= 32'(i_item.texture_sel) * i_smult;
        r_s2 <= r_s1;
        r_nz <= w_x;
        if (w_push_q) begin
            r_q[r_wp] <= '{req_type: r_s2.req_type, pix_x: r_s2.pix_x,
                           pix_y: r_s2.pix_y, texture_sel: r_s2.texture_sel,
                           rule_slot: r_s2.rule_slot, word_sel: r_s2.word_sel,
                           word_value: r_s2.word_value, noise: r_nz};
        end
    end

    assign o_job       = r_q[r_rp];
    assign o_job_valid = r_cnt != 2'd0;

`include "procedural_texel_generator_top_macros.svh"
    `PTG_ASSERT_IMP(a_occ_bound, i_clk, i_rst_n, 1'b1, w_occ <= 2'd2)
    `PTG_ASSERT_NXT(a_s1_to_s2, i_clk, i_rst_n, r_s1_v, r_s2_v)
    `PTG_ASSERT_IMP(a_no_pop_empty, i_clk, i_rst_n, r_cnt == 2'd0, !w_pop_q)
endmodule

// ===== design/ptg_back.sv =====
// ============================================================================
// Texel generator back end
// Writes rule words and runs the serial rule search for texel jobs.
// ============================================================================
module ptg_back
    import ptg_pkg::*;
#(
    parameter int NUM_TEXTURES = NumTexturesDef,
    parameter int RULES_PER_TEXTURE = RulesPerTextureDef
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_job       i_job,
    input  logic       i_job_valid,
    output logic       o_job_take,
    input  logic [7:0] i_alpha,
    output t_out_item  o_item,
    output logic       o_empty,
    input  logic       i_pop
);
    localparam int NumRules = NUM_TEXTURES * RULES_PER_TEXTURE;
    localparam int RuleBits = (NumRules > 1) ? $clog2(NumRules) : 1;
    localparam int SlotBits = (RULES_PER_TEXTURE > 1) ? $clog2(RULES_PER_TEXTURE) : 1;
    localparam int Depth = NumRules * WordsPerRule;
    localparam int AddrBits = $clog2(Depth);

    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_NEXT  = 14'b00000000000010,
        S_LOAD  = 14'b00000000000100,
        S_XDIV  = 14'b00000000001000,
        S_YDIV  = 14'b00000000010000,
        S_TERM1 = 14'b00000000100000,
        S_TERM2 = 14'b00000001000000,
        S_MOD   = 14'b00000010000000,
        S_KMOD  = 14'b00000100000000,
        S_MIXM  = 14'b00001000000000,
        S_MIXD  = 14'b00010000000000,
        S_DONE  = 14'b00100000000000,
        S_OUT   = 14'b01000000000000,
        S_WAIT  = 14'b10000000000000
    } t_state;

    t_state r_st, n_st;
    logic [NumRules-1:0] r_valid;
    logic [31:0] r_w [WordsPerRule];
    logic [4:0]  r_ld;
    logic [SlotBits:0] r_slot;
    t_job        r_job;
    logic [31:0] r_acc, r_tmp, r_n;
    logic [1:0]  r_ch;
    logic [7:0]  r_rgb [3];
    logic [1:0]  r_fault;
    t_out_item   r_out;
    logic        r_out_v;

    logic        w_we;
    logic [AddrBits-1:0] w_addr;
    logic [31:0] w_wdata, w_rdata;
    logic        w_div_start, w_div_done;
    logic signed [32:0] w_num, w_den, w_quo, w_rem;
    logic [RuleBits-1:0] w_rule;
    logic        w_wr_ok;
    logic [7:0]  w_ca, w_cb;
    logic [31:0] w_term, w_mix;

    assign w_rule = RuleBits'(32'(r_job.texture_sel) * RULES_PER_TEXTURE
                    + 32'(r_slot[SlotBits-1:0]));
    assign w_wr_ok = 32'(i_job.texture_sel) < NUM_TEXTURES
                  && 32'(i_job.rule_slot) < RULES_PER_TEXTURE;

    always_comb begin
        w_we    = 1'b0;
        w_wdata = i_job.word_value;
        w_addr  = {w_rule, r_ld[3:0]};
        if (r_st == S_IDLE && i_job_valid && i_job.req_type) begin
            w_we   = w_wr_ok && i_job.word_sel < 5'(WordSelValid);
            w_addr = AddrBits'((32'(i_job.texture_sel) * RULES_PER_TEXTURE
                     + 32'(i_job.rule_slot)) * WordsPerRule + 32'(i_job.word_sel[3:0]));
        end
    end

    ptg_ram #(.WIDTH(32), .DEPTH(Depth)) u_ram (
        .i_clk(i_clk), .i_we(w_we), .i_addr(w_addr), .i_wdata(w_wdata),
        .o_rdata(w_rdata)
    );

    ptg_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_div_start),
        .i_num(w_num), .i_den(w_den), .o_done(w_div_done),
        .o_quo(w_quo), .o_rem(w_rem)
    );

    always_comb begin
        case (r_ch)
            2'd0:    begin w_ca = r_w[W_CA][23:16]; w_cb = r_w[W_CB][23:16]; end
            2'd1:    begin w_ca = r_w[W_CA][15:8];  w_cb = r_w[W_CB][15:8];  end
            default: begin w_ca = r_w[W_CA][7:0];   w_cb = r_w[W_CB][7:0];   end
        endcase
    end

    assign w_term = r_tmp + r_acc + r_n;
    assign w_mix  = 32'(32'(w_ca) * (r_w[W_D] - r_n) + 32'(w_cb) * r_n);

    assign o_job_take = (r_st == S_IDLE) && i_job_valid;

    always_comb begin
        n_st = r_st;
        w_div_start = 1'b0;
        w_num = 33'(signed'({1'b0, r_job.pix_x}));
        w_den = 33'(signed'(r_w[W_XD]));
        case (r_st)
            S_IDLE: begin
                if (i_job_valid && !i_job.req_type) begin
                    n_st = (32'(i_job.texture_sel) < NUM_TEXTURES) ? S_NEXT : S_DONE;
                end
            end
            S_NEXT: begin
                if (32'(r_slot) >= RULES_PER_TEXTURE) begin
                    n_st = S_DONE;
                end else if (r_valid[w_rule]) begin
                    n_st = S_LOAD;
                end
            end
            S_LOAD: begin
                if (r_ld == 5'd16) begin
                    if ($signed(r_w[W_XD]) <= 0 || $signed(r_w[W_YD]) <= 0) begin
                        n_st = S_DONE;
                    end else begin
                        w_div_start = 1'b1;
                        n_st = S_XDIV;
                    end
                end
            end
            S_XDIV: begin
                if (w_div_done) begin
                    w_div_start = 1'b1;
                    w_num = 33'(signed'({1'b0, r_job.pix_y}));
                    w_den = 33'(signed'(r_w[W_YD]));
                    n_st = S_YDIV;
                end
            end
            S_YDIV: if (w_div_done) n_st = S_TERM1;
            S_TERM1: n_st = S_TERM2;
            S_TERM2: begin
                if (r_w[W_PKIND] == PK_ALWAYS) begin
                    n_st = S_MIXM;
                end else if (r_w[W_PKIND] == PK_EQ || r_w[W_PKIND] == PK_LT) begin
                    if ($signed(r_w[W_M]) <= 0) begin
                        n_st = S_DONE;
                    end else begin
                        w_div_start = 1'b1;
                        w_num = 33'(signed'(w_term));
                        w_den = 33'(signed'(r_w[W_M]));
                        n_st = S_MOD;
                    end
                end else begin
                    n_st = S_NEXT;
                end
            end
            S_MOD: begin
                if (w_div_done) begin
                    n_st = S_NEXT;
                    if ((r_w[W_PKIND] == PK_EQ && w_rem == 33'(signed'(r_w[W_E])))
                        || (r_w[W_PKIND] == PK_LT && w_rem < 33'(signed'(r_w[W_L])))) begin
                        n_st = S_MIXM;
                    end
                end
            end
            S_MIXM: begin
                if (r_w[W_RKIND] != RK_MIX) begin
                    n_st = S_DONE;
                end else if ($signed(r_w[W_K]) <= 0 || $signed(r_w[W_D]) <= 0) begin
                    n_st = S_DONE;
                end else begin
                    w_div_start = 1'b1;
                    w_num = 33'(signed'(r_job.noise));
                    w_den = 33'(signed'(r_w[W_K]));
                    n_st = S_KMOD;
                end
            end
            S_KMOD: if (w_div_done) n_st = S_WAIT;
            S_WAIT: begin
                w_div_start = 1'b1;
                w_num = 33'(signed'(w_mix));
                w_den = 33'(signed'(r_w[W_D]));
                n_st = S_MIXD;
            end
            S_MIXD: begin
                if (w_div_done) begin
                    n_st = (r_ch == 2'd2) ? S_DONE : S_WAIT;
                end
            end
            S_DONE: if (!r_out_v) n_st = S_OUT;
            S_OUT:  n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_IDLE;
            r_valid <= '0;
            r_out_v <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_st == S_IDLE && i_job_valid && i_job.req_type && w_wr_ok
                && i_job.word_sel == 5'(WordSelValid)) begin
                r_valid[RuleBits'(32'(i_job.texture_sel) * RULES_PER_TEXTURE
                        + 32'(i_job.rule_slot))] <= i_job.word_value[0];
            end
            if (r_st == S_OUT) begin
                r_out_v <= 1'b1;
            end else if (i_pop && r_out_v) begin
                r_out_v <= 1'b0;
            end
        end
        case (r_st)
            S_IDLE: begin
                r_job   <= i_job;
                r_slot  <= '0;
                r_ld    <= '0;
                r_fault <= FAULT_NONE;
            end
            S_NEXT: begin
                r_ld <= '0;
                if (!r_valid[w_rule] && 32'(r_slot) < RULES_PER_TEXTURE) begin
                    r_slot <= r_slot + 1'b1;
                end
            end
            S_LOAD: begin
                if (r_ld != 5'd0 && r_ld <= 5'd16) begin
                    r_w[r_ld[3:0] - 4'd1] <= w_rdata;
                end
                if (r_ld != 5'd16) begin
                    r_ld <= r_ld + 5'd1;
                end else if ($signed(r_w[W_XD]) <= 0 || $signed(r_w[W_YD]) <= 0) begin
                    r_fault <= FAULT_DIV;
                end
            end
            S_XDIV: if (w_div_done) r_tmp <= w_quo[31:0];
            S_YDIV: if (w_div_done) r_acc <= w_quo[31:0];
            S_TERM1: begin
                r_tmp <= r_w[W_XM] * r_tmp;
                r_acc <= r_w[W_YM] * r_acc;
                r_n   <= r_w[W_NM] * r_job.noise;
            end
            S_TERM2: begin
                r_acc <= w_term;
                if (r_w[W_PKIND] != PK_ALWAYS) begin
                    if (r_w[W_PKIND] == PK_EQ || r_w[W_PKIND] == PK_LT) begin
                        if ($signed(r_w[W_M]) <= 0) begin
                            r_fault <= FAULT_DIV;
                        end
                    end else begin
                        r_slot <= r_slot + 1'b1;
                    end
                end
            end
            S_MOD: if (w_div_done && n_st == S_NEXT) r_slot <= r_slot + 1'b1;
            S_MIXM: begin
                r_ch <= 2'd0;
                if (r_w[W_RKIND] != RK_MIX) begin
                    r_rgb[0] <= r_w[W_SOLID][23:16];
                    r_rgb[1] <= r_w[W_SOLID][15:8];
                    r_rgb[2] <= r_w[W_SOLID][7:0];
                    r_fault  <= FAULT_OK;
                end else if ($signed(r_w[W_K]) <= 0 || $signed(r_w[W_D]) <= 0) begin
                    r_fault <= FAULT_DIV;
                end
            end
            S_KMOD: begin
                if (w_div_done) begin
                    r_n <= r_w[W_BASE] + w_rem[31:0];
                end
            end
            S_MIXD: begin
                if (w_div_done) begin
                    r_rgb[r_ch] <= w_quo[7:0];
                    r_ch <= r_ch + 2'd1;
                    if (r_ch == 2'd2) begin
                        r_fault <= FAULT_OK;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_v) begin
                    r_out.fault <= r_fault;
                    if (r_fault == FAULT_OK) begin
                        r_out.red   <= r_rgb[0];
                        r_out.green <= r_rgb[1];
                        r_out.blue  <= r_rgb[2];
                        r_out.alpha <= i_alpha;
                    end else begin
                        r_out.red   <= '0;
                        r_out.green <= '0;
                        r_out.blue  <= '0;
                        r_out.alpha <= '0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign o_item  = r_out;
    assign o_empty = !r_out_v;

`include "procedural_texel_generator_top_macros.svh"
    `PTG_ASSERT_IMP(a_take_idle, i_clk, i_rst_n, o_job_take, r_st == S_IDLE)
    `PTG_ASSERT_NXT(a_out_after, i_clk, i_rst_n, r_st == S_OUT, r_out_v)
    `PTG_ASSERT_IMP(a_onehot, i_clk, i_rst_n, 1'b1, $onehot(r_st))
endmodule
